// ----- rtl/tccw_pkg.sv -----
// Package for the text console cell writer.
// Holds the beat payload types, command and character codes, register
// indexes and the controller-to-datapath command and status structs.
package tccw_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_MOVE   = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Character codes with special meaning.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCROLL_ENABLE = 2'd0;
    localparam logic [1:0] REG_SCROLL_FIRST  = 2'd1;
    localparam logic [1:0] REG_SCROLL_LAST   = 2'd2;

    // Sweep setup kinds issued by the controller.
    localparam logic [2:0] SET_NONE  = 3'd0;
    localparam logic [2:0] SET_CLEAR = 3'd1;
    localparam logic [2:0] SET_DEL   = 3'd2;
    localparam logic [2:0] SET_LAST  = 3'd3;
    localparam logic [2:0] SET_COPY  = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [6:0] target_col;
        logic [5:0] target_row;
        logic [5:0] line_count;
    } item_t;

    typedef struct packed {
        logic [6:0] cursor_col_out;
        logic [5:0] cursor_row_out;
        logic [7:0] cell_data;
    } result_t;

    typedef struct packed {
        logic       load;
        logic [2:0] setup;
        logic       fill_step;
        logic       copy_rd;
        logic       copy_wr;
        logic       rd_issue;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       newline;
        logic       scroll_hit;
        logic       del_nonzero;
        logic       col_last;
        logic       row_done;
        logic       copy_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/tccw_datapath.sv -----
// Datapath of the text console cell writer: cell memory, cursor, sweep
// counters, item and result registers. Depends on tccw_pkg.
module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 50
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    input  logic     scroll_enable,
    input  logic [5:0] scroll_first,
    input  logic [5:0] scroll_last,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] COL_MAX = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_addr = AW'(AW'(r) * AW'(COLS) + AW'(c));
    endfunction

    // Latched item, with column and row saturated on entry.
    logic [2:0]    cmd_reg;
    logic [7:0]    ch_reg;
    logic [CW-1:0] tc_reg;
    logic [RW-1:0] tr_reg;
    logic [5:0]    nl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= item.cmd;
            ch_reg  <= item.char_code;
            tc_reg  <= (item.target_col > 7'(COLS - 1)) ? COL_MAX : item.target_col[CW-1:0];
            tr_reg  <= (item.target_row > 6'(ROWS - 1)) ? ROW_MAX : item.target_row[RW-1:0];
            nl_reg  <= item.line_count;
        end
    end

    // Cursor and sweep state.
    logic [CW-1:0] cc_reg, cc_next;
    logic [RW-1:0] cr_reg, cr_next;
    logic [RW-1:0] sw_row_reg, sw_row_next;
    logic [CW-1:0] sw_col_reg, sw_col_next;
    logic [RW-1:0] end_row_reg, end_row_next;
    logic [7:0]    fill_reg, fill_next;
    logic [7:0]    rdata_reg;
    logic          out_valid_reg;
    result_t       result_reg;

    // Decoded conditions.
    logic          region_active;
    logic          scroll_hit;
    logic [5:0]    cr6;
    logic [5:0]    del_end6;
    logic [RW-1:0] del_end;
    logic          is_bs;

    assign region_active = scroll_enable && (scroll_first < scroll_last)
                           && ({1'b0, scroll_last} < 7'(ROWS));
    assign cr6        = 6'(cr_reg);
    assign scroll_hit = region_active && (cr6 == scroll_last);
    assign del_end6   = (nl_reg > cr6) ? 6'd0 : 6'(cr6 - nl_reg + 6'd1);
    assign del_end    = del_end6[RW-1:0];
    assign is_bs      = (ch_reg == CH_BS) || (ch_reg == CH_DEL);

    assign stat.cmd         = cmd_reg;
    assign stat.newline     = (ch_reg == CH_NEWLINE);
    assign stat.scroll_hit  = scroll_hit;
    assign stat.del_nonzero = (nl_reg != 6'd0);
    assign stat.col_last    = (sw_col_reg == COL_MAX);
    assign stat.row_done    = (sw_row_reg == end_row_reg);
    assign stat.copy_done   = (6'(sw_row_reg) + 6'd1 == scroll_last);
    assign stat.out_free    = !out_valid_reg || !result_stall;

    // Sweep counter next values.
    always_comb
    begin
        sw_row_next  = sw_row_reg;
        sw_col_next  = sw_col_reg;
        end_row_next = end_row_reg;
        fill_next    = fill_reg;
        case (cmd.setup)
            SET_CLEAR:
            begin
                sw_row_next  = ROW_MAX;
                end_row_next = '0;
                sw_col_next  = '0;
                fill_next    = CH_SPACE;
            end
            SET_DEL:
            begin
                sw_row_next  = cr_reg;
                end_row_next = del_end;
                sw_col_next  = '0;
                fill_next    = CH_SPACE;
            end
            SET_LAST:
            begin
                sw_row_next  = scroll_last[RW-1:0];
                end_row_next = scroll_last[RW-1:0];
                sw_col_next  = '0;
                fill_next    = CH_SPACE;
            end
            SET_COPY:
            begin
                sw_row_next = scroll_first[RW-1:0];
                sw_col_next = '0;
            end
            default: ;
        endcase
        if (cmd.fill_step)
        begin
            if (stat.col_last)
            begin
                sw_col_next = '0;
                if (!stat.row_done)
                    sw_row_next = sw_row_reg - 1'b1;
            end
            else
                sw_col_next = sw_col_reg + 1'b1;
        end
        if (cmd.copy_wr)
        begin
            if (stat.col_last)
            begin
                sw_col_next = '0;
                sw_row_next = sw_row_reg + 1'b1;
            end
            else
                sw_col_next = sw_col_reg + 1'b1;
        end
    end

    // Cursor update and result data on finish.
    logic [7:0] data_next;

    always_comb
    begin
        cc_next   = cc_reg;
        cr_next   = cr_reg;
        data_next = 8'd0;
        case (cmd_reg)
            CMD_WRITE:
            begin
                if (ch_reg == CH_NEWLINE)
                begin
                    cc_next = '0;
                    if (!scroll_hit && cr_reg != ROW_MAX)
                        cr_next = cr_reg + 1'b1;
                end
                else if (is_bs)
                begin
                    if (cc_reg != '0)
                        cc_next = cc_reg - 1'b1;
                    else if (cr_reg != '0)
                    begin
                        cc_next = COL_MAX;
                        cr_next = cr_reg - 1'b1;
                    end
                end
                else if (cc_reg == COL_MAX)
                begin
                    cc_next = '0;
                    if (cr_reg != ROW_MAX)
                        cr_next = cr_reg + 1'b1;
                end
                else
                    cc_next = cc_reg + 1'b1;
            end
            CMD_MOVE:
            begin
                cc_next = tc_reg;
                cr_next = tr_reg;
            end
            CMD_CLEAR:
            begin
                cc_next = '0;
                cr_next = '0;
            end
            CMD_DELETE:
            begin
                if (nl_reg != 6'd0)
                begin
                    cc_next = '0;
                    cr_next = del_end;
                end
            end
            CMD_READ:
                data_next = rdata_reg;
            default: ;
        endcase
    end

    // Memory port selection.
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;

    always_comb
    begin
        we    = 1'b0;
        waddr = cell_addr(sw_row_reg, sw_col_reg);
        wdata = fill_reg;
        if (cmd.fill_step)
            we = 1'b1;
        else if (cmd.copy_wr)
        begin
            we    = 1'b1;
            wdata = rdata_reg;
        end
        else if (cmd.finish && cmd_reg == CMD_WRITE && ch_reg != CH_NEWLINE)
        begin
            if (!is_bs)
            begin
                we    = 1'b1;
                waddr = cell_addr(cr_reg, cc_reg);
                wdata = ch_reg;
            end
            else if (cc_reg != '0)
            begin
                we    = 1'b1;
                waddr = cell_addr(cr_reg, cc_reg - 1'b1);
                wdata = CH_SPACE;
            end
        end
    end

    assign re    = cmd.copy_rd || cmd.rd_issue;
    assign raddr = cmd.copy_rd ? cell_addr(sw_row_reg + 1'b1, sw_col_reg)
                               : cell_addr(tr_reg, tc_reg);

    // Character cell memory.
    logic [7:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg        <= '0;
            cr_reg        <= '0;
            sw_row_reg    <= ROW_MAX;
            sw_col_reg    <= '0;
            end_row_reg   <= '0;
            fill_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sw_row_reg  <= sw_row_next;
            sw_col_reg  <= sw_col_next;
            end_row_reg <= end_row_next;
            fill_reg    <= fill_next;
            if (cmd.finish)
            begin
                cc_reg <= cc_next;
                cr_reg <= cr_next;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            result_reg <= '{cursor_col_out: 7'(cc_next),
                            cursor_row_out: 6'(cr_next),
                            cell_data: data_next};
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // A finish never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result overwritten while stalled");

    // The cursor stays inside the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cc_reg) < COLS) && (32'(cr_reg) < ROWS))
        else $error("cursor outside the screen");

    // Sweeps stay inside the screen.
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_step || cmd.copy_wr) |-> (32'(sw_row_reg) < ROWS))
        else $error("sweep row outside the screen");

endmodule

// ----- rtl/tccw_ctrl.sv -----
// Controller of the text console cell writer: sequences the clearing
// pass, item intake, row sweeps and the result. Depends on tccw_pkg.
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_CPRD = 3'd3;
    localparam logic [2:0] S_CPWR = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;
    localparam logic [2:0] S_FILL = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign item_stall = !(state_reg == S_IDLE && stat.out_free);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.fill_step = 1'b1;
                if (stat.row_done && stat.col_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.cmd)
                    CMD_WRITE:
                    begin
                        // A newline on the last row of an active region scrolls it.
                        if (stat.scroll_hit && stat.newline)
                        begin
                            cmd.setup  = SET_COPY;
                            state_next = S_CPRD;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd.setup  = SET_CLEAR;
                        state_next = S_FILL;
                    end
                    CMD_DELETE:
                    begin
                        if (stat.del_nonzero)
                        begin
                            cmd.setup  = SET_DEL;
                            state_next = S_FILL;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_FIN;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CPRD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_CPWR;
            end
            S_CPWR:
            begin
                cmd.copy_wr = 1'b1;
                if (stat.col_last && stat.copy_done)
                    state_next = S_LAST;
                else
                    state_next = S_CPRD;
            end
            S_LAST:
            begin
                cmd.setup  = SET_LAST;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.row_done && stat.col_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // Items are taken only in idle.
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("item taken outside idle");

    // Every copy read is followed by its write.
    a_copy_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_rd |=> cmd.copy_wr)
        else $error("copy read without write");

    // A loaded item is dispatched in the next cycle.
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DISP))
        else $error("loaded item not dispatched");

endmodule

// ----- rtl/text_console_cell_writer.sv -----
// Text console cell writer, top level: configuration registers on an
// APB-style port, controller and datapath. Depends on tccw_pkg.
//
// Use: command beats arrive on item/item_valid/item_stall, one result beat
// per command leaves on result/result_valid/result_stall. A beat moves at
// a rising edge with valid high and stall low.
// Sequence per command: write char, move, newline with no scroll and delete
// of zero lines finish straight from dispatch; read cell reads the memory
// first; clear and delete of n lines blank their rows one cell per step; a
// newline that scrolls copies each row of the region up by one, a read and
// then a write per cell, and then blanks the last row. A new command beat
// is taken only once the result of the last one has been produced.
// The cell memory has one write port and one read port.
// After reset the block runs a clearing pass that zeros the memory;
// item_stall stays high meanwhile, register writes still work.
// A stalled result is held in the output register; the next command beat
// is taken in the cycle the held result leaves.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic       scroll_enable_reg;
    logic [5:0] scroll_first_reg;
    logic [5:0] scroll_last_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_enable_reg <= 1'b0;
            scroll_first_reg  <= 6'd0;
            scroll_last_reg   <= 6'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SCROLL_ENABLE: scroll_enable_reg <= pwdata[0];
                REG_SCROLL_FIRST:  scroll_first_reg  <= pwdata[5:0];
                REG_SCROLL_LAST:   scroll_last_reg   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCROLL_ENABLE: prdata = {31'd0, scroll_enable_reg};
            REG_SCROLL_FIRST:  prdata = {26'd0, scroll_first_reg};
            REG_SCROLL_LAST:   prdata = {26'd0, scroll_last_reg};
            default:           prdata = 32'd0;
        endcase
    end

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tccw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tccw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .stat          (stat),
        .scroll_enable (scroll_enable_reg),
        .scroll_first  (scroll_first_reg),
        .scroll_last   (scroll_last_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

endmodule
